FILE: hdl/sawr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawr_pkg
// shared types, event and status codes for the stop-and-wait sender
// ----------------------------------------------------------------------------
package sawr_pkg;

	// event kinds
	localparam logic [1:0] FN_HANDSHAKE = 2'd0;
	localparam logic [1:0] FN_DATA_ACK  = 2'd1;
	localparam logic [1:0] FN_TIMEOUT   = 2'd2;
	localparam logic [1:0] FN_CLOSE     = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TIMEOUT   = 2'd1;
	localparam logic [1:0] ST_BAD_REPLY = 2'd2;
	localparam logic [1:0] ST_BAD_ACK   = 2'd3;

	localparam logic [47:0] PACKET_BYTES = 48'd1472;
	localparam logic [19:0] MIN_DEV_RESET = 20'd10000;

	typedef struct packed {
		logic [1:0]  func;
		logic        syn_flag;
		logic        ack_flag;
		logic        fin_flag;
		logic [31:0] ack_number;
		logic [31:0] peer_window;
		logic [23:0] rtt_sample_us;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] next_seq;
		logic [31:0] window;
		logic [31:0] timeout_total;
		logic [47:0] acked_bytes;
		logic        connected;
	} ctrl_res_t;

endpackage

FILE: hdl/sawr_rtt_est.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawr_rtt_est
// smoothed rtt, deviation and retransmission timeout state
// ----------------------------------------------------------------------------
module sawr_rtt_est (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  sawr_pkg::item_t item,
	input  logic [19:0]   min_dev_us,
	output logic [26:0]   rto_next
);
	import sawr_pkg::*;

	logic [26:0] est_q;
	logic [25:0] dev_q;
	logic [26:0] rto_q;

	logic [29:0] est_x7;
	logic [27:0] est_upd;
	logic [26:0] est_new;
	logic [26:0] s8;
	logic [26:0] diff;
	logic [27:0] dev_x3;
	logic [26:0] dev_upd;
	logic [25:0] dev_new;
	logic [25:0] floor4;
	logic [25:0] dev_max;
	logic [27:0] rto_sum;
	logic [26:0] rto_upd;
	logic [26:0] rto_hs;

	always_comb begin
		// est * 7 / 8 plus the new sample
		est_x7  = {est_q, 3'b000} - {3'b000, est_q};
		est_upd = {1'b0, est_x7[29:3]} + {4'b0000, item.rtt_sample_us};
		est_new = est_upd[26:0];
		s8      = {item.rtt_sample_us, 3'b000};
		diff    = (s8 >= est_new) ? (s8 - est_new) : (est_new - s8);
		// dev * 3 / 4 plus |diff| / 8
		dev_x3  = {1'b0, dev_q, 1'b0} + {2'b00, dev_q};
		dev_upd = {1'b0, dev_x3[27:2]} + {3'b000, diff[26:3]};
		dev_new = dev_upd[25:0];
		floor4  = {4'b0000, min_dev_us, 2'b00};
		dev_max = (dev_new > floor4) ? dev_new : floor4;
		rto_sum = {4'b0000, est_new[26:3]} + {2'b00, dev_max};
		rto_upd = rto_sum[27] ? '1 : rto_sum[26:0];
		rto_hs  = {2'b00, item.rtt_sample_us, 1'b0} + {3'b000, item.rtt_sample_us};
	end

	always_comb begin
		rto_next = rto_q;
		if (fire) begin
			unique case (item.func)
				FN_HANDSHAKE: rto_next = rto_hs;
				FN_DATA_ACK:  rto_next = rto_upd;
				default:      rto_next = rto_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= '0;
			dev_q <= '0;
			rto_q <= '0;
		end else if (fire) begin
			unique case (item.func)
				FN_HANDSHAKE: begin
					est_q <= {item.rtt_sample_us, 3'b000};
					rto_q <= rto_hs;
				end
				FN_DATA_ACK: begin
					est_q <= est_new;
					dev_q <= dev_new;
					rto_q <= rto_upd;
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: hdl/sawr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawr_ctrl
// sequence, window, counters, link state and status of each event
// ----------------------------------------------------------------------------
module sawr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  sawr_pkg::item_t    item,
	output sawr_pkg::ctrl_res_t res
);
	import sawr_pkg::*;

	logic [31:0] seq_q;
	logic [31:0] window_q;
	logic [31:0] timeout_q;
	logic [47:0] bytes_q;
	logic        link_q;

	logic [31:0] seq_inc;
	ctrl_res_t   nxt;

	assign seq_inc = seq_q + 32'd1;

	always_comb begin
		nxt.status        = ST_OK;
		nxt.next_seq      = seq_q;
		nxt.window        = window_q;
		nxt.timeout_total = timeout_q;
		nxt.acked_bytes   = bytes_q;
		nxt.connected     = link_q;
		unique case (item.func)
			FN_HANDSHAKE: begin
				if (item.syn_flag && item.ack_flag) begin
					nxt.window    = item.peer_window;
					nxt.connected = 1'b1;
				end else begin
					nxt.status = ST_BAD_REPLY;
				end
			end
			FN_DATA_ACK: begin
				if (item.ack_number == seq_inc) begin
					nxt.window      = item.peer_window;
					nxt.next_seq    = seq_inc;
					nxt.acked_bytes = bytes_q + PACKET_BYTES;
				end else begin
					nxt.status = ST_BAD_ACK;
				end
			end
			FN_TIMEOUT: begin
				nxt.timeout_total = timeout_q + 32'd1;
				nxt.status        = ST_TIMEOUT;
			end
			FN_CLOSE: begin
				if (item.fin_flag && item.ack_flag) begin
					nxt.connected = 1'b0;
				end else begin
					nxt.status = ST_BAD_REPLY;
				end
			end
		endcase
	end

	assign res = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q     <= '0;
			window_q  <= '0;
			timeout_q <= '0;
			bytes_q   <= '0;
			link_q    <= 1'b0;
		end else if (fire) begin
			seq_q     <= nxt.next_seq;
			window_q  <= nxt.window;
			timeout_q <= nxt.timeout_total;
			bytes_q   <= nxt.acked_bytes;
			link_q    <= nxt.connected;
		end
	end

`ifndef SYNTHESIS
	a_timeout_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.func == FN_TIMEOUT) |=> (timeout_q == $past(timeout_q) + 32'd1))
		else $error("timeout count did not advance by one");

	a_seq_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.func == FN_DATA_ACK && nxt.status == ST_OK)
		|=> (seq_q == $past(seq_q) + 32'd1 && bytes_q == $past(bytes_q) + PACKET_BYTES))
		else $error("good ack did not advance sequence and byte count");
`endif

endmodule

FILE: hdl/stop_and_wait_sender_rto.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_sender_rto
// sender-side stop-and-wait bookkeeping with a smoothed-rtt rto estimator
// ----------------------------------------------------------------------------
// path: an accepted request is held in the input register, then its result
//   in the result register
// throughput: one request per cycle while results are taken; set by the
//   update of the rtt/deviation/rto state, which the next request reads
// reset: all connection and timing state clears to zero, min_dev_us loads
//   10000; no clearing pass, requests are taken right after reset
// ----------------------------------------------------------------------------
module stop_and_wait_sender_rto (
	input  logic         clk,
	input  logic         arst_n,
	// request stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// syn_flag, ack_flag, fin_flag, ack_number[31:0], peer_window[31:0],
	// rtt_sample_us[23:0], zero pad[4:0]
	input  logic [95:0]  s_tdata,
	// func[1:0]
	input  logic [1:0]   s_tuser,
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0], rto_us[26:0], next_seq[31:0], window[31:0],
	// timeout_total[31:0], acked_bytes[47:0], connected, zero pad[1:0]
	output logic [175:0] m_tdata,
	// configuration: min_dev_us
	input  logic         cfg_we,
	input  logic [19:0]  cfg_wdata
);
	import sawr_pkg::*;

	// configuration register
	logic [19:0] min_dev_q;

	// input register stage
	logic        valid_s1;
	item_t       item_s1;

	// result register
	logic        m_valid_q;
	logic [175:0] m_data_q;

	logic        advance;
	logic        fire;
	logic        s_acc;
	logic [26:0] rto_next;
	ctrl_res_t   ctrl_res;

	// result register frees when empty or when being taken this cycle
	assign advance  = !m_valid_q || m_tready;
	// the request in the input register is processed when it can move on
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dev_q <= MIN_DEV_RESET;
		end else if (cfg_we) begin
			min_dev_q <= cfg_wdata;
		end
	end

	// input register: unpack the request fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			item_s1.func          <= s_tuser;
			item_s1.syn_flag      <= s_tdata[0];
			item_s1.ack_flag      <= s_tdata[1];
			item_s1.fin_flag      <= s_tdata[2];
			item_s1.ack_number    <= s_tdata[34:3];
			item_s1.peer_window   <= s_tdata[66:35];
			item_s1.rtt_sample_us <= s_tdata[90:67];
		end
	end

	// timing estimator: rto after this request
	sawr_rtt_est u_rtt (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.min_dev_us (min_dev_q),
		.rto_next   (rto_next)
	);

	// sequence, counters and link state
	sawr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (ctrl_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_data_q <= {2'b00, ctrl_res.connected, ctrl_res.acked_bytes,
				ctrl_res.timeout_total, ctrl_res.window, ctrl_res.next_seq,
				rto_next, ctrl_res.status};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef SYNTHESIS
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> valid_s1)
		else $error("accepted request not held in input register");

	a_fire_emits: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid)
		else $error("processed request produced no result");
`endif

endmodule
